// ----- hw/rtl/dtc_pkg.sv -----
// ---------------------------------------------------------------------------
// dtc_pkg
// Shared constants, function codes and digit helpers for the decisecond
// time-of-day clock.
// ---------------------------------------------------------------------------
package dtc_pkg;

	typedef enum logic [1:0] {
		FUNC_TICK = 2'd0,
		FUNC_SET  = 2'd1,
		FUNC_READ = 2'd2
	} func_t;

	localparam logic [19:0] DayTenths    = 20'd864000;
	localparam logic [19:0] HourTenths   = 20'd36000;
	localparam logic [15:0] MinuteTenths = 16'd600;
	localparam logic [6:0]  SetCmdLen    = 7'd14;
	localparam logic [6:0]  ReadCmdLen   = 7'd4;

	// floor(x / 36000) = (x * HourRecip) >> HourShift, exact for x below 2**21
	localparam logic [20:0] HourRecip = 21'd1908875;
	localparam int          HourShift = 36;
	// floor(x / 600) = (x * MinuteRecip) >> MinuteShift, exact for x below 2**16
	localparam logic [16:0] MinuteRecip = 17'd111849;
	localparam int          MinuteShift = 26;

	localparam logic [7:0] ChSpace  = 8'h20;
	localparam logic [7:0] ChColon  = 8'h3A;
	localparam logic [7:0] ChPeriod = 8'h2E;
	localparam logic [7:0] ChZero   = 8'h30;
	localparam logic [7:0] ChTwo    = 8'h32;
	localparam logic [7:0] ChNine   = 8'h39;

	// divide by ten for values below 1024
	function automatic logic [6:0] div10(input logic [9:0] x);
		logic [17:0] p;
		p = 18'(x) * 18'd205;
		return p[17:11];
	endfunction

	// divide by one hundred for values below 1024
	function automatic logic [3:0] div100(input logic [9:0] x);
		logic [15:0] p;
		p = 16'(x) * 16'd41;
		return p[15:12];
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= ChZero) && (c <= ChNine);
	endfunction

endpackage

// ----- hw/rtl/dtc_if.sv -----
// ---------------------------------------------------------------------------
// dtc_if
// Valid/ready channels of the decisecond clock: command words in, display
// words out.
// ---------------------------------------------------------------------------
interface dtc_cmd_if;
	logic        valid;
	logic        ready;
	logic [1:0]  func;
	logic        clock_select;
	logic [6:0]  text_length;
	logic [55:0] text_front;
	logic [31:0] text_back;

	modport source(output valid, func, clock_select, text_length, text_front, text_back,
		input ready);
	modport sink(input valid, func, clock_select, text_length, text_front, text_back,
		output ready);
endinterface

interface dtc_disp_if;
	logic       valid;
	logic       ready;
	logic [1:0] hour_tens;
	logic [3:0] hour_ones;
	logic [2:0] minute_tens;
	logic [3:0] minute_ones;
	logic [2:0] second_tens;
	logic [3:0] second_ones;
	logic [3:0] tenths;
	logic       bad_command;

	modport source(output valid, hour_tens, hour_ones, minute_tens, minute_ones,
		second_tens, second_ones, tenths, bad_command, input ready);
	modport sink(input valid, hour_tens, hour_ones, minute_tens, minute_ones,
		second_tens, second_ones, tenths, bad_command, output ready);
endinterface

// ----- hw/rtl/decisecond_time_of_day_clock.sv -----
// ---------------------------------------------------------------------------
// decisecond_time_of_day_clock
// Time-of-day and stopwatch counters in tenths of a second, with command
// parsing and a digit display for every command word.
// ---------------------------------------------------------------------------
// Each command word passes through the stage registers and then the output register.
// Throughput: one word per cycle while the display sink is ready; the counter
// read-modify-write sits in one stage, so back-to-back words see each other's updates.
// Stages stall only as far back as the first empty stage.
// Reset clears both counters and all stage valids.
module decisecond_time_of_day_clock (
	input logic        clk,
	input logic        arst_n,
	dtc_cmd_if.sink    cmd,
	dtc_disp_if.source disp
);
	import dtc_pkg::*;

	// stage valids and load enables
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, out_v_q;
	logic ld1, ld2, ld3, ld4, ld5, ld6, ld_out;

	assign ld_out = !out_v_q || disp.ready;
	assign ld6    = !v_s6 || ld_out;
	assign ld5    = !v_s5 || ld6;
	assign ld4    = !v_s4 || ld5;
	assign ld3    = !v_s3 || ld4;
	assign ld2    = !v_s2 || ld3;
	assign ld1    = !v_s1 || ld2;
	assign cmd.ready = ld1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			v_s5    <= 1'b0;
			v_s6    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (ld1)    v_s1    <= cmd.valid;
			if (ld2)    v_s2    <= v_s1;
			if (ld3)    v_s3    <= v_s2;
			if (ld4)    v_s4    <= v_s3;
			if (ld5)    v_s5    <= v_s4;
			if (ld6)    v_s6    <= v_s5;
			if (ld_out) out_v_q <= v_s6;
		end
	end

	// stage 1: command word register
	func_t       func_s1;
	logic        sel_s1;
	logic [6:0]  len_s1;
	logic [55:0] front_s1;
	logic [31:0] back_s1;

	always_ff @(posedge clk) begin
		if (ld1) begin
			func_s1  <= func_t'(cmd.func);
			sel_s1   <= cmd.clock_select;
			len_s1   <= cmd.text_length;
			front_s1 <= cmd.text_front;
			back_s1  <= cmd.text_back;
		end
	end

	// parse the set command text
	logic [7:0]  ch3, ch4, ch5, ch6, ch7, ch8, ch9, ch10, ch11, ch12, ch13;
	logic        fmt_ok;
	logic [20:0] set_value;
	logic        bad_d1;
	logic        sel_d1;

	assign ch3  = front_s1[7:0];
	assign ch4  = front_s1[15:8];
	assign ch5  = front_s1[23:16];
	assign ch6  = front_s1[31:24];
	assign ch7  = front_s1[39:32];
	assign ch8  = front_s1[47:40];
	assign ch9  = front_s1[55:48];
	assign ch10 = back_s1[7:0];
	assign ch11 = back_s1[15:8];
	assign ch12 = back_s1[23:16];
	assign ch13 = back_s1[31:24];

	assign fmt_ok = (len_s1 == SetCmdLen) && (ch3 == ChSpace) && (ch6 == ChColon)
		&& (ch9 == ChColon) && (ch12 == ChPeriod) && (ch4 >= ChZero) && (ch4 <= ChTwo)
		&& is_digit(ch5) && is_digit(ch7) && is_digit(ch8) && is_digit(ch10)
		&& is_digit(ch11) && is_digit(ch13);

	// ascii digits carry their value in the low nibble
	assign set_value = 21'(ch4[3:0]) * 21'd360000 + 21'(ch5[3:0]) * 21'd36000
		+ 21'(ch7[3:0]) * 21'd6000 + 21'(ch8[3:0]) * 21'd600
		+ 21'(ch10[3:0]) * 21'd100 + 21'(ch11[3:0]) * 21'd10 + 21'(ch13[3:0]);

	always_comb begin
		sel_d1 = sel_s1;
		case (func_s1)
			FUNC_TICK: bad_d1 = 1'b0;
			FUNC_SET: begin
				bad_d1 = !fmt_ok;
				sel_d1 = 1'b0;
			end
			FUNC_READ: bad_d1 = (len_s1 != ReadCmdLen);
			default:   bad_d1 = 1'b1;
		endcase
	end

	// stage 2: parsed command, counter update
	func_t       func_s2;
	logic        sel_s2;
	logic        bad_s2;
	logic        load_s2;
	logic [20:0] value_s2;

	always_ff @(posedge clk) begin
		if (ld2) begin
			func_s2  <= func_s1;
			sel_s2   <= sel_d1;
			bad_s2   <= bad_d1;
			load_s2  <= (func_s1 == FUNC_SET) && fmt_ok;
			value_s2 <= set_value;
		end
	end

	logic [19:0] cnt_q [2];
	logic [19:0] cnt_d [2];
	logic        bad_d2;

	always_comb begin
		cnt_d  = cnt_q;
		bad_d2 = bad_s2;
		case (func_s2)
			FUNC_TICK: begin
				if (cnt_q[sel_s2] == DayTenths - 20'd1)
					cnt_d[sel_s2] = '0;
				else
					cnt_d[sel_s2] = cnt_q[sel_s2] + 20'd1;
			end
			FUNC_SET: begin
				if (load_s2) begin
					if (value_s2 < {1'b0, DayTenths})
						cnt_d[0] = value_s2[19:0];
					else
						bad_d2 = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// the counters move only when the word leaves stage 2
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q[0] <= '0;
			cnt_q[1] <= '0;
		end else if (v_s2 && ld3) begin
			cnt_q <= cnt_d;
		end
	end

	// stage 3: shown count
	logic [19:0] cnt_s3;
	logic        bad_s3;

	always_ff @(posedge clk) begin
		if (ld3) begin
			cnt_s3 <= cnt_d[sel_s2];
			bad_s3 <= bad_d2;
		end
	end

	// stage 4: hours by reciprocal multiply
	logic [40:0] hour_prod;
	logic [4:0]  hours_s4;
	logic [19:0] cnt_s4;
	logic        bad_s4;

	assign hour_prod = 41'(cnt_s3) * 41'(HourRecip);

	always_ff @(posedge clk) begin
		if (ld4) begin
			hours_s4 <= hour_prod[HourShift +: 5];
			cnt_s4   <= cnt_s3;
			bad_s4   <= bad_s3;
		end
	end

	// stage 5: hour digits and minutes
	logic [19:0] hour_rem;
	logic [15:0] rem1;
	logic [32:0] min_prod;
	logic [6:0]  hour_t;
	logic [1:0]  hour_tens_s5;
	logic [3:0]  hour_ones_s5;
	logic [5:0]  mins_s5;
	logic [15:0] rem1_s5;
	logic        bad_s5;

	assign hour_rem = cnt_s4 - 20'(hours_s4) * HourTenths;
	assign rem1     = hour_rem[15:0];
	assign min_prod = 33'(rem1) * 33'(MinuteRecip);
	assign hour_t   = div10(10'(hours_s4));

	always_ff @(posedge clk) begin
		if (ld5) begin
			hour_tens_s5 <= hour_t[1:0];
			hour_ones_s5 <= 4'(hours_s4 - 5'(hour_t[1:0]) * 5'd10);
			mins_s5      <= min_prod[MinuteShift +: 6];
			rem1_s5      <= rem1;
			bad_s5       <= bad_s4;
		end
	end

	// stage 6: minute digits and remaining tenths within the minute
	logic [15:0] min_rem;
	logic [6:0]  min_t;
	logic [1:0]  hour_tens_s6;
	logic [3:0]  hour_ones_s6;
	logic [2:0]  min_tens_s6;
	logic [3:0]  min_ones_s6;
	logic [9:0]  rem2_s6;
	logic        bad_s6;

	assign min_rem = rem1_s5 - 16'(mins_s5) * MinuteTenths;
	assign min_t   = div10(10'(mins_s5));

	always_ff @(posedge clk) begin
		if (ld6) begin
			hour_tens_s6 <= hour_tens_s5;
			hour_ones_s6 <= hour_ones_s5;
			min_tens_s6  <= min_t[2:0];
			min_ones_s6  <= 4'(mins_s5 - 6'(min_t[2:0]) * 6'd10);
			rem2_s6      <= min_rem[9:0];
			bad_s6       <= bad_s5;
		end
	end

	// output register: second and tenth digits
	logic [6:0] secs;
	logic [3:0] sec_t;
	logic [1:0] hour_tens_q;
	logic [3:0] hour_ones_q;
	logic [2:0] min_tens_q;
	logic [3:0] min_ones_q;
	logic [2:0] sec_tens_q;
	logic [3:0] sec_ones_q;
	logic [3:0] tenths_q;
	logic       bad_q;

	assign secs  = div10(rem2_s6);
	assign sec_t = div100(rem2_s6);

	always_ff @(posedge clk) begin
		if (ld_out) begin
			hour_tens_q <= hour_tens_s6;
			hour_ones_q <= hour_ones_s6;
			min_tens_q  <= min_tens_s6;
			min_ones_q  <= min_ones_s6;
			sec_tens_q  <= sec_t[2:0];
			sec_ones_q  <= 4'(secs - 7'(sec_t) * 7'd10);
			tenths_q    <= 4'(rem2_s6 - 10'(secs) * 10'd10);
			bad_q       <= bad_s6;
		end
	end

	assign disp.valid       = out_v_q;
	assign disp.hour_tens   = hour_tens_q;
	assign disp.hour_ones   = hour_ones_q;
	assign disp.minute_tens = min_tens_q;
	assign disp.minute_ones = min_ones_q;
	assign disp.second_tens = sec_tens_q;
	assign disp.second_ones = sec_ones_q;
	assign disp.tenths      = tenths_q;
	assign disp.bad_command = bad_q;

	// both counters stay within one day
	assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q[0] < DayTenths) && (cnt_q[1] < DayTenths))
		else $error("tenth counter out of range");

	// a displayed word with hour tens of two or more never shows an hour ones digit above three
	assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q |-> (hour_tens_q < 2'd2) || (hour_ones_q < 4'd4))
		else $error("displayed hour out of range");

	// a counter only changes when a word leaves the update stage
	assert property (@(posedge clk) disable iff (!arst_n)
		!(v_s2 && ld3) |=> $stable(cnt_q[0]) && $stable(cnt_q[1]))
		else $error("counter changed without a word");

	// ones and tenths digits below ten, minute and second tens below six, in every displayed word
	assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q |-> (hour_ones_q < 4'd10) && (min_ones_q < 4'd10) && (min_tens_q < 3'd6)
			&& (sec_ones_q < 4'd10) && (sec_tens_q < 3'd6) && (tenths_q < 4'd10))
		else $error("digit out of range");

endmodule
